/* rtl/bdqs_pkg.sv */
// Shared types and constants for the bounded deque with search.
package bdqs_pkg;

    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SEARCH     = 3'd4
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a transaction, arm the scan
        logic exec;       // perform push/pop/unused mode and issue its result
        logic scan;       // advance the search walk by one entry
        logic finish;     // issue the search result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;      // compared entry equals the searched value
        logic exhausted;  // every stored entry compared, none matched
    } t_status;

endpackage

/* rtl/bdqs_ctrl.sv */
// Controller state machine for the bounded deque with search.
module bdqs_ctrl
    import bdqs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MODE_W-1:0]   i_mode,
    input  t_status             i_status,
    output t_cmd                o_cmd,
    output logic                o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_mode == MODE_SEARCH) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                if (i_status.match || i_status.exhausted) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/bdqs_dpath.sv */
// Datapath for the bounded deque with search: ring storage, pointers, scan and results.
module bdqs_dpath
    import bdqs_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [MODE_W-1:0]           i_mode,
    input  logic signed [VALUE_W-1:0]   i_value,
    output t_status                     o_status,
    output logic                        o_done,
    output logic                        o_ok,
    output logic                        o_found,
    output logic [POS_OUT_W-1:0]        o_position,
    output logic [CNT_OUT_W-1:0]        o_count
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [MODE_W-1:0]  r_mode;
    logic [VALUE_W-1:0] r_value;
    logic [PW-1:0]      r_front;
    logic [CW-1:0]      r_count;
    logic [PW-1:0]      r_addr;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_cmp_idx;
    logic               r_rv;
    logic [VALUE_W-1:0] r_rdata;
    logic               r_done;
    logic               r_ok;
    logic               r_found;
    logic [CW-1:0]      r_pos;

    logic [PW-1:0]      n_front;
    logic [CW-1:0]      n_count;
    logic               n_ok;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic [PW-1:0]      front_dec;
    logic [PW-1:0]      front_inc;
    logic [PW-1:0]      back_addr;
    logic [SW-1:0]      back_sum;
    logic [PW-1:0]      addr_inc;
    logic               full;
    logic               empty;

    assign full      = (r_count == CAP_CNT);
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign addr_inc  = (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
    // front + count wraps at most once
    assign back_sum  = SW'(r_front) + SW'(r_count);
    assign back_addr = (back_sum >= CAP_SUM) ? PW'(back_sum - CAP_SUM) : PW'(back_sum);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = back_addr;
        unique case (r_mode)
            MODE_PUSH_FRONT: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (!empty) begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (!empty) begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_value;
        end
        r_rdata <= mem[r_addr];
    end

    // transaction capture, scan walk and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_addr  <= r_front;
            r_idx   <= '0;
        end else if (i_cmd.scan && (r_idx != r_count)) begin
            r_addr <= addr_inc;
            r_idx  <= r_idx + 1'b1;
        end
        r_cmp_idx <= r_idx;
        if (i_cmd.exec) begin
            r_ok    <= n_ok;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_cmd.finish) begin
            r_ok    <= 1'b0;
            r_found <= o_status.match;
            r_pos   <= o_status.match ? r_cmp_idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            r_rv   <= i_cmd.scan && (r_idx != r_count);
            r_done <= i_cmd.exec || i_cmd.finish;
        end
    end

    assign o_status.match     = r_rv && (r_rdata == r_value);
    assign o_status.exhausted = !r_rv && (r_idx == r_count);

    assign o_done     = r_done;
    assign o_ok       = r_ok;
    assign o_found    = r_found;
    assign o_position = POS_OUT_W'(r_pos);
    assign o_count    = CNT_OUT_W'(r_count);

endmodule

/* rtl/bounded_deque_with_search_core.sv */
// Top level of the bounded deque with search: controller plus datapath.
//
// A transaction is taken when start is high while busy is low. Its result
// appears for one cycle with o_done high and must be captured then; there is
// no way to hold it off. A push or removal (and an unused mode) is performed
// in the S_EXEC state and returns its result from the registered done flag. A
// search walks the stored entries from the front through a single registered
// read port of the entry memory, one entry per cycle, and returns once a match
// is found or all N stored entries are compared, N being the current entry count.
// busy drops in the cycle o_done is shown, so the next transaction may start there.
// o_count is the entry count after the operation, truncated to five bits;
// o_position is truncated to four bits.
module bounded_deque_with_search_core
    import bdqs_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [MODE_W-1:0]           i_mode,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        o_done,
    output logic                        o_ok,
    output logic                        o_found,
    output logic [POS_OUT_W-1:0]        o_position,
    output logic [CNT_OUT_W-1:0]        o_count
);

    t_cmd    cmd;
    t_status status;

    bdqs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bdqs_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_status   (status),
        .o_done     (o_done),
        .o_ok       (o_ok),
        .o_found    (o_found),
        .o_position (o_position),
        .o_count    (o_count)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result issued while still busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_ok_vs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_ok && o_found))
        else $error("result reports both ok and found");

endmodule
